FILE: rtl/lzssrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssrw_pkg
// Shared types and constants for the lzss ring window decompressor.
// ----------------------------------------------------------------------------
package lzssrw_pkg;

  localparam int WIN_AW    = 12;
  localparam int WIN_DEPTH = 1 << WIN_AW;
  localparam int LEN_W     = 17;
  localparam int COPY_W    = 5;

  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(65536);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       overrun_error;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LIT   = 2'd1,
    CMD_COPY  = 2'd2,
    CMD_ERR   = 2'd3
  } cmd_kind_t;

  // one unit of work for the back end
  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         data;
    logic [WIN_AW-1:0]  src;
    logic [COPY_W-1:0]  len;
    logic               last;
  } cmd_t;

endpackage

FILE: rtl/lzssrw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssrw_front
// Parses the compressed byte stream: header, flag bytes, literals and copy
// tokens. Turns chunk starts, literals, copy tokens and header overruns into commands for the back end.
// ----------------------------------------------------------------------------
module lzssrw_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lzssrw_pkg::in_item_t          in_item,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lzssrw_pkg::LEN_W-1:0]  cfg_data,
  input  logic                          q_full,
  output logic                          push,
  output lzssrw_pkg::cmd_t              push_cmd
);
  import lzssrw_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HDR_HI = 6'b000010,
    PH_FLAG   = 6'b000100,
    PH_LIT    = 6'b001000,
    PH_TOK_LO = 6'b010000,
    PH_TOK_HI = 6'b100000
  } phase_t;

  phase_t             phase, phase_next;
  logic [LEN_W-1:0]   output_limit;
  logic [LEN_W-1:0]   remaining, remaining_next;
  logic [7:0]         flag_shift, flag_shift_next;
  logic [3:0]         flags_left, flags_left_next;
  logic [7:0]         held, held_next;

  logic               accept;
  logic [LEN_W-1:0]   hdr_len;
  logic [COPY_W-1:0]  tok_len;
  logic [COPY_W-1:0]  clip;
  logic [LEN_W-1:0]   item_rem;
  logic [7:0]         shift_adv;
  logic [3:0]         left_adv;
  phase_t             item_phase;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign hdr_len = {1'b0, in_item.in_byte, held} + LEN_W'(1);
  assign tok_len = {1'b0, in_item.in_byte[7:4]} + COPY_W'(3);
  assign clip    = ({{(LEN_W-COPY_W){1'b0}}, tok_len} > remaining) ?
                   remaining[COPY_W-1:0] : tok_len;

  // remaining count and phase after one literal or copy item
  assign item_rem  = (phase == PH_LIT) ? remaining - LEN_W'(1) :
                     remaining - {{(LEN_W-COPY_W){1'b0}}, clip};
  assign shift_adv = {1'b0, flag_shift[7:1]};
  assign left_adv  = flags_left - 4'd1;

  always_comb begin
    if (item_rem == '0) begin
      item_phase = PH_IDLE;
    end else if (left_adv == 4'd0) begin
      item_phase = PH_FLAG;
    end else if (shift_adv[0]) begin
      item_phase = PH_LIT;
    end else begin
      item_phase = PH_TOK_LO;
    end
  end

  always_comb begin
    phase_next      = phase;
    remaining_next  = remaining;
    flag_shift_next = flag_shift;
    flags_left_next = flags_left;
    held_next       = held;
    push            = 1'b0;
    push_cmd        = '{kind: CMD_CLEAR, data: in_item.in_byte,
                        src: {in_item.in_byte[3:0], held}, len: clip,
                        last: 1'b0};
    if (accept) begin
      if (in_item.chunk_start) begin
        push            = 1'b1;
        push_cmd.kind   = CMD_CLEAR;
        held_next       = in_item.in_byte;
        remaining_next  = '0;
        flag_shift_next = '0;
        flags_left_next = '0;
        phase_next      = PH_HDR_HI;
      end else begin
        case (phase)
          PH_HDR_HI: begin
            if (hdr_len > output_limit) begin
              push          = 1'b1;
              push_cmd.kind = CMD_ERR;
              push_cmd.last = 1'b1;
              phase_next    = PH_IDLE;
            end else begin
              remaining_next = hdr_len;
              phase_next     = PH_FLAG;
            end
          end
          PH_FLAG: begin
            flag_shift_next = in_item.in_byte;
            flags_left_next = 4'd8;
            phase_next      = in_item.in_byte[0] ? PH_LIT : PH_TOK_LO;
          end
          PH_LIT: begin
            push            = 1'b1;
            push_cmd.kind   = CMD_LIT;
            push_cmd.last   = (item_rem == '0);
            remaining_next  = item_rem;
            phase_next      = item_phase;
            if (item_rem != '0) begin
              flag_shift_next = shift_adv;
              flags_left_next = left_adv;
            end
          end
          PH_TOK_LO: begin
            held_next  = in_item.in_byte;
            phase_next = PH_TOK_HI;
          end
          PH_TOK_HI: begin
            push            = 1'b1;
            push_cmd.kind   = CMD_COPY;
            push_cmd.last   = (item_rem == '0);
            remaining_next  = item_rem;
            phase_next      = item_phase;
            if (item_rem != '0) begin
              flag_shift_next = shift_adv;
              flags_left_next = left_adv;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      output_limit <= LIMIT_RESET;
      remaining    <= '0;
      flag_shift   <= '0;
      flags_left   <= '0;
      held         <= '0;
    end else begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      flag_shift <= flag_shift_next;
      flags_left <= flags_left_next;
      held       <= held_next;
      if (cfg_valid && cfg_ready) begin
        output_limit <= cfg_data;
      end
    end
  end

endmodule

FILE: rtl/lzssrw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssrw_queue
// Small command fifo between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzssrw_queue #(
  parameter int DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  lzssrw_pkg::cmd_t              push_cmd,
  input  logic                          pop,
  output lzssrw_pkg::cmd_t              head,
  output logic                          empty,
  output logic                          full,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import lzssrw_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

FILE: rtl/lzssrw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssrw_back
// Copy engine: owns the ring window, emits literals and copies one byte per
// cycle while out_stall is low, through a read stage and an output register.
// ----------------------------------------------------------------------------
module lzssrw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  lzssrw_pkg::cmd_t      head,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lzssrw_pkg::out_item_t out_item
);
  import lzssrw_pkg::*;

  localparam logic [WIN_AW:0] WIN_FULL = (WIN_AW+1)'(WIN_DEPTH);

  logic [7:0]        window [WIN_DEPTH];
  logic [7:0]        rdata;

  logic              adv, s0_go, is_copy, copy_end;
  logic [COPY_W-1:0] cnt;
  logic [WIN_AW-1:0] raddr;
  logic [WIN_AW-1:0] wpos;
  logic [WIN_AW:0]   fill;

  logic              s1_valid;
  cmd_kind_t         s1_kind;
  logic [7:0]        s1_byte;
  logic              s1_last, s1_err, s1_zero, s1_fwd;
  logic [7:0]        s1_fwd_data;
  logic [7:0]        s1_data;
  logic              s1_writes, s1_clearing, we, hit;

  assign adv      = !out_valid || !out_stall;
  assign s0_go    = adv && !q_empty;
  assign is_copy  = (head.kind == CMD_COPY);
  assign copy_end = ((cnt + COPY_W'(1)) == head.len);
  assign raddr    = head.src + {{(WIN_AW-COPY_W){1'b0}}, cnt};
  assign pop      = s0_go && (!is_copy || copy_end);

  assign s1_writes   = s1_valid && (s1_kind inside {CMD_LIT, CMD_COPY});
  assign s1_clearing = s1_valid && (s1_kind == CMD_CLEAR);
  assign we          = adv && s1_writes;
  // read of the byte written in the same cycle takes the bypass path
  assign hit         = s1_writes && (raddr == wpos);

  always_comb begin
    if (s1_kind != CMD_COPY) begin
      s1_data = s1_byte;
    end else if (s1_fwd) begin
      s1_data = s1_fwd_data;
    end else if (s1_zero) begin
      s1_data = 8'd0;
    end else begin
      s1_data = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      window[wpos] <= s1_data;
    end
    if (s0_go && is_copy) begin
      rdata <= window[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
      wpos      <= '0;
      fill      <= '0;
    end else if (adv) begin
      s1_valid  <= !q_empty;
      out_valid <= s1_valid && (s1_kind != CMD_CLEAR);
      if (s0_go) begin
        cnt <= pop ? '0 : cnt + COPY_W'(1);
      end
      if (s1_clearing) begin
        wpos <= '0;
        fill <= '0;
      end else if (we) begin
        wpos <= wpos + WIN_AW'(1);
        if (fill != WIN_FULL) begin
          fill <= fill + (WIN_AW+1)'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= '{out_byte: s1_data, last: s1_last, overrun_error: s1_err};
      if (s0_go) begin
        s1_kind     <= head.kind;
        s1_byte     <= (head.kind == CMD_ERR) ? 8'd0 : head.data;
        s1_last     <= is_copy ? (head.last && copy_end) : head.last;
        s1_err      <= (head.kind == CMD_ERR);
        // entries past the fill count were never written this chunk
        s1_zero     <= s1_clearing || ({1'b0, raddr} >= fill);
        s1_fwd      <= hit;
        s1_fwd_data <= s1_data;
      end
    end
  end

endmodule

FILE: rtl/lzss_ring_window_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_ring_window_decompressor
// LZSS decompressor with a 4096-byte ring window: parser front end, command
// queue, and a copy engine that emits one decompressed byte per cycle while out_stall is low.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in        input      in_valid/in_stall  in_item (in_byte, chunk_start)
//  out       output     out_valid/out_stall out_item (out_byte, last, overrun_error)
//  cfg       input      cfg_valid/cfg_ready cfg_data (output_limit)
//
//  the parser takes one input byte per cycle while the command queue has room
//  the copy engine emits one byte per cycle while out_stall is low; a copy token yields 1 to 18
//  bytes, so a token's two bytes cost up to 18 reads at the window read port
//  each result passes through the command queue, the read stage and the output register
//  no clearing pass after reset or chunk start: a fill count marks written entries
//  out_stall holds the output register and freezes the copy engine only
// ----------------------------------------------------------------------------
module lzss_ring_window_decompressor #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lzssrw_pkg::in_item_t          in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lzssrw_pkg::out_item_t         out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lzssrw_pkg::LEN_W-1:0]  cfg_data
);
  import lzssrw_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH+1);

  logic            push, pop, q_empty, q_full;
  cmd_t            push_cmd, head;
  logic [QCW-1:0]  q_count;

  assign cfg_ready = 1'b1;

  lzssrw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  lzssrw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full),
    .count    (q_count)
  );

  lzssrw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.overrun_error |-> out_item.last && out_item.out_byte == 8'd0)
    else $error("overrun result without last or with nonzero byte");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCW'(QUEUE_DEPTH))
    else $error("command queue count beyond depth");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && q_count == '0)
    else $error("output or queue not empty after reset");
`endif

endmodule
